// ===== design/vrt_pkg.sv =====
// Voxel ray traversal package: field widths, codes, payload structs and
// the quarter-wave sine table builder. No dependencies.
package vrt_pkg;

    localparam int COORD_INT_BITS  = 24;
    localparam int COORD_FRAC_BITS = 8;
    localparam int ANGLE_BITS      = 12;
    localparam int DIST_FRAC_BITS  = 16;

    localparam int POS_W   = COORD_INT_BITS + COORD_FRAC_BITS;
    localparam int QUARTER = 1 << (ANGLE_BITS - 2);
    localparam int ADDR_W  = ANGLE_BITS - 1;
    localparam int MAG_W   = 31;
    localparam int DVD_W   = 31 + DIST_FRAC_BITS;
    localparam int DIST_W  = 32;

    localparam logic [MAG_W-1:0]  EPS_Q30  = MAG_W'(1074);
    localparam logic [DIST_W-1:0] DIST_SAT = '1;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_ANSWER = 1'b1;

    localparam logic [1:0] CELL_AIR   = 2'd0;
    localparam logic [1:0] CELL_SOLID = 2'd1;

    localparam logic [1:0] KIND_QUERY       = 2'd0;
    localparam logic [1:0] KIND_HIT         = 2'd1;
    localparam logic [1:0] KIND_MISS_RANGE  = 2'd2;
    localparam logic [1:0] KIND_MISS_UNLOAD = 2'd3;

    localparam logic [0:0] REG_MAX_RANGE  = 1'd0;
    localparam logic [0:0] REG_EYE_HEIGHT = 1'd1;

    typedef struct packed {
        logic                         operation;
        logic signed [POS_W-1:0]      eye_x;
        logic signed [POS_W-1:0]      eye_y;
        logic signed [POS_W-1:0]      eye_z;
        logic [ANGLE_BITS-1:0]        yaw_angle;
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic [1:0]                   cell_state;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                       kind;
        logic signed [COORD_INT_BITS-1:0] voxel_x;
        logic signed [COORD_INT_BITS-1:0] voxel_y;
        logic signed [COORD_INT_BITS-1:0] voxel_z;
        logic [2:0]                       entry_face;
    } out_item_t;

    typedef logic [31:0] sine_rom_t [0:QUARTER];

    // Integer Taylor series, Q2.30, truncating, capped at 1.0.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        for (int i = 0; i <= QUARTER; i++)
        begin
            x  = (64'(i) * 64'd1686629713) >> (ANGLE_BITS - 2);
            x2 = (x * x) >> 30;
            t  = 64'd1 << 30;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd156;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd110;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
            s  = (x * t) >> 30;
            if (s > (64'd1 << 30))
            begin
                s = 64'd1 << 30;
            end
            r[i] = s[31:0];
        end
        return r;
    endfunction

endpackage

// ===== design/vrt_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on vrt_pkg for operand widths.
module vrt_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [vrt_pkg::DVD_W-1:0]   dividend,
    input  logic [vrt_pkg::MAG_W-1:0]   divisor,
    output logic                        done,
    output logic [vrt_pkg::DVD_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(vrt_pkg::DVD_W + 1);

    logic [vrt_pkg::MAG_W:0]     rem_reg;
    logic [vrt_pkg::DVD_W-1:0]   quo_reg;
    logic [vrt_pkg::MAG_W-1:0]   dvs_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [vrt_pkg::MAG_W+1:0]   trial;
    logic [vrt_pkg::MAG_W+1:0]   diff;

    assign trial = {rem_reg, quo_reg[vrt_pkg::DVD_W-1]};
    assign diff  = trial - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(vrt_pkg::DVD_W);
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                // dividend bits shift out the top, quotient bits in the bottom
                if (!diff[vrt_pkg::MAG_W+1])
                begin
                    rem_reg <= diff[vrt_pkg::MAG_W:0];
                    quo_reg <= {quo_reg[vrt_pkg::DVD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[vrt_pkg::MAG_W:0];
                    quo_reg <= {quo_reg[vrt_pkg::DVD_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/voxel_ray_traversal_top.sv =====
// Voxel ray traversal top level: sequencer, sine table, shared multiplier.
// Depends on vrt_pkg and vrt_div.
//
// 3D DDA voxel walker. A start transfer (operation 0) sets up a ray from the
// eye position plus eye_height along the yaw/pitch direction and returns the
// first query (or a miss beyond range when max_range is zero). Each answer
// transfer (operation 1) returns the next query, a hit, or a miss; answers
// with no ray in flight are dropped without a result. in_ready is high only
// while the sequencer is idle. A start runs from the accepting edge until the
// block is idle again through four sine table reads, two products on the
// shared multiplier, then six divisions on the one bit-per-cycle divider (an
// increment and a first crossing per axis), then pick axis, step and deliver;
// with zero range the pick and step are skipped. An air answer within range
// goes through accept, pick axis, step and deliver; a hit or a miss goes from
// accept straight to deliver, and an answer with no ray in flight is only
// accepted. Delivery waits while the output register still holds an untaken
// result. The output register holds a result until taken; the block accepts
// the next transfer meanwhile. Configuration writes (cfg_we) are taken any
// cycle but are meant only while idle.
module voxel_ray_traversal_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  vrt_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output vrt_pkg::out_item_t out_item,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int CIB = vrt_pkg::COORD_INT_BITS;
    localparam int CFB = vrt_pkg::COORD_FRAC_BITS;
    localparam int AB  = vrt_pkg::ANGLE_BITS;
    localparam int DFB = vrt_pkg::DIST_FRAC_BITS;
    localparam int PW  = vrt_pkg::POS_W;
    localparam int MW  = vrt_pkg::MAG_W;
    localparam int DW  = vrt_pkg::DVD_W;
    localparam int ADDR_W_L = vrt_pkg::ADDR_W;

    localparam vrt_pkg::sine_rom_t SINE_ROM = vrt_pkg::build_sine_rom();

    typedef enum logic [3:0] {
        ST_IDLE, ST_SIN, ST_SIN_WAIT, ST_MUL, ST_MUL_WAIT,
        ST_DIV, ST_DIV_WAIT, ST_PICK, ST_STEP, ST_EMIT
    } state_t;

    state_t             state_reg;
    logic [2:0]         cnt_reg;
    logic [15:0]        max_range_reg;
    logic [9:0]         eye_height_reg;
    logic [PW-1:0]      pos_reg [3];
    logic [AB-1:0]      yaw_reg;
    logic [AB-1:0]      pitch_reg;
    logic [31:0]        rom_q_reg;
    logic [MW-1:0]      sin_mag_reg [4];
    logic               sin_neg_reg [4];
    logic [2*MW-1:0]    prod_reg;
    logic [MW-1:0]      d_mag_reg [3];
    logic               d_neg_reg [3];
    logic [CIB-1:0]     cur_voxel_reg [3];
    logic               step_sign_reg [3];
    logic [31:0]        next_cross_reg [3];
    logic [31:0]        cross_inc_reg [3];
    logic [31:0]        travelled_reg;
    logic [2:0]         face_reg;
    logic               ray_active_reg;
    logic [1:0]         axis_reg;
    logic [1:0]         pend_kind_reg;
    logic               out_valid_reg;
    vrt_pkg::out_item_t out_item_reg;

    logic [31:0]        range_q;
    logic [9+CFB:0]     eh_wide;
    logic [AB-1:0]      angle;
    logic [AB-3:0]      rem_a;
    logic [ADDR_W_L-1:0] sin_addr;
    logic [1:0]         div_axis;
    logic               pos_dir;
    logic [CFB-1:0]     frac;
    logic [CFB:0]       num;
    logic [DW-1:0]      div_dvd;
    logic               div_start;
    logic               div_done;
    logic [DW-1:0]      div_quo;
    logic [31:0]        div_res;
    logic [2:0]         face_step;
    logic [32:0]        cross_sum;
    logic               out_free;

    assign range_q = 32'({16'd0, max_range_reg} << (DFB - 8));
    assign eh_wide = {eye_height_reg, {CFB{1'b0}}} >> 8;

    // sine lookup: 0 sin yaw, 1 cos yaw, 2 sin pitch, 3 cos pitch
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    angle = yaw_reg;
            2'd1:    angle = yaw_reg + AB'(vrt_pkg::QUARTER);
            2'd2:    angle = pitch_reg;
            default: angle = pitch_reg + AB'(vrt_pkg::QUARTER);
        endcase
    end
    assign rem_a    = angle[AB-3:0];
    assign sin_addr = angle[AB-2] ? ADDR_W_L'(vrt_pkg::QUARTER) - ADDR_W_L'(rem_a)
                                  : ADDR_W_L'(rem_a);

    // division operands: even count is the increment, odd the first crossing
    assign div_axis = cnt_reg[2:1];
    assign pos_dir  = (d_mag_reg[div_axis] != '0) && !d_neg_reg[div_axis];
    assign frac     = pos_reg[div_axis][CFB-1:0];
    assign num      = pos_dir ? ((CFB+1)'(1) << CFB) - {1'b0, frac} : {1'b0, frac};
    assign div_dvd  = cnt_reg[0] ? (DW'(num) << (30 + DFB - CFB)) : (DW'(1) << (30 + DFB));
    assign div_start = (state_reg == ST_DIV);
    assign div_res  = ((d_mag_reg[div_axis] < vrt_pkg::EPS_Q30) || (div_quo[DW-1:32] != '0))
                      ? vrt_pkg::DIST_SAT : div_quo[31:0];

    vrt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (d_mag_reg[div_axis]),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign cross_sum = {1'b0, next_cross_reg[axis_reg]} + {1'b0, cross_inc_reg[axis_reg]};
    assign face_step = {axis_reg, 1'b0} + {2'b00, !step_sign_reg[axis_reg]};
    assign out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        rom_q_reg <= SINE_ROM[sin_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            max_range_reg  <= 16'd1280;
            eye_height_reg <= 10'd410;
            travelled_reg  <= '0;
            face_reg       <= '0;
            ray_active_reg <= 1'b0;
            axis_reg       <= '0;
            pend_kind_reg  <= vrt_pkg::KIND_QUERY;
            out_valid_reg  <= 1'b0;
            out_item_reg   <= '0;
            yaw_reg        <= '0;
            pitch_reg      <= '0;
            prod_reg       <= '0;
            for (int j = 0; j < 3; j++)
            begin
                pos_reg[j]        <= '0;
                d_mag_reg[j]      <= '0;
                d_neg_reg[j]      <= 1'b0;
                cur_voxel_reg[j]  <= '0;
                step_sign_reg[j]  <= 1'b0;
                next_cross_reg[j] <= '0;
                cross_inc_reg[j]  <= '0;
            end
            for (int j = 0; j < 4; j++)
            begin
                sin_mag_reg[j] <= '0;
                sin_neg_reg[j] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == vrt_pkg::REG_MAX_RANGE)
                begin
                    max_range_reg <= cfg_data;
                end
                else
                begin
                    eye_height_reg <= cfg_data[9:0];
                end
            end

            // in ST_EMIT the delivery below decides out_valid
            if (out_valid_reg && out_ready && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (in_item.operation == vrt_pkg::OP_START)
                        begin
                            pos_reg[0] <= in_item.eye_x;
                            pos_reg[1] <= in_item.eye_y + PW'(eh_wide);
                            pos_reg[2] <= in_item.eye_z;
                            yaw_reg    <= in_item.yaw_angle;
                            pitch_reg  <= in_item.pitch_angle;
                            cnt_reg    <= '0;
                            state_reg  <= ST_SIN;
                        end
                        else if (ray_active_reg)
                        begin
                            if (in_item.cell_state == vrt_pkg::CELL_AIR)
                            begin
                                if (travelled_reg >= range_q)
                                begin
                                    pend_kind_reg <= vrt_pkg::KIND_MISS_RANGE;
                                    state_reg     <= ST_EMIT;
                                end
                                else
                                begin
                                    state_reg <= ST_PICK;
                                end
                            end
                            else if (in_item.cell_state == vrt_pkg::CELL_SOLID)
                            begin
                                pend_kind_reg <= vrt_pkg::KIND_HIT;
                                state_reg     <= ST_EMIT;
                            end
                            else
                            begin
                                pend_kind_reg <= vrt_pkg::KIND_MISS_UNLOAD;
                                state_reg     <= ST_EMIT;
                            end
                        end
                    end
                end

                ST_SIN:
                begin
                    state_reg <= ST_SIN_WAIT;
                end

                ST_SIN_WAIT:
                begin
                    sin_mag_reg[cnt_reg[1:0]] <= rom_q_reg[MW-1:0];
                    sin_neg_reg[cnt_reg[1:0]] <= angle[AB-1];
                    if (cnt_reg == 3'd3)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= ST_SIN;
                    end
                end

                ST_MUL:
                begin
                    // x = cos(yaw)cos(pitch), z = sin(yaw)cos(pitch)
                    prod_reg  <= (cnt_reg[0] ? sin_mag_reg[0] : sin_mag_reg[1])
                                 * sin_mag_reg[3];
                    state_reg <= ST_MUL_WAIT;
                end

                ST_MUL_WAIT:
                begin
                    if (cnt_reg[0])
                    begin
                        d_mag_reg[2] <= prod_reg[30 +: MW];
                        d_neg_reg[2] <= sin_neg_reg[0] ^ sin_neg_reg[3];
                        d_mag_reg[1] <= sin_mag_reg[2];
                        d_neg_reg[1] <= sin_neg_reg[2];
                        cnt_reg      <= '0;
                        state_reg    <= ST_DIV;
                    end
                    else
                    begin
                        d_mag_reg[0] <= prod_reg[30 +: MW];
                        d_neg_reg[0] <= sin_neg_reg[1] ^ sin_neg_reg[3];
                        cnt_reg      <= cnt_reg + 1'b1;
                        state_reg    <= ST_MUL;
                    end
                end

                ST_DIV:
                begin
                    state_reg <= ST_DIV_WAIT;
                end

                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        if (cnt_reg[0])
                        begin
                            next_cross_reg[div_axis] <= div_res;
                            cur_voxel_reg[div_axis]  <= pos_reg[div_axis][PW-1:CFB];
                            step_sign_reg[div_axis]  <= !pos_dir;
                        end
                        else
                        begin
                            cross_inc_reg[div_axis] <= div_res;
                        end
                        if (cnt_reg == 3'd5)
                        begin
                            travelled_reg  <= '0;
                            face_reg       <= '0;
                            ray_active_reg <= 1'b1;
                            if (range_q == '0)
                            begin
                                pend_kind_reg <= vrt_pkg::KIND_MISS_RANGE;
                                state_reg     <= ST_EMIT;
                            end
                            else
                            begin
                                state_reg <= ST_PICK;
                            end
                        end
                        else
                        begin
                            cnt_reg   <= cnt_reg + 1'b1;
                            state_reg <= ST_DIV;
                        end
                    end
                end

                ST_PICK:
                begin
                    // nearest crossing; ties go to the higher axis
                    if (next_cross_reg[0] < next_cross_reg[1])
                    begin
                        axis_reg <= (next_cross_reg[0] < next_cross_reg[2]) ? 2'd0 : 2'd2;
                    end
                    else
                    begin
                        axis_reg <= (next_cross_reg[1] < next_cross_reg[2]) ? 2'd1 : 2'd2;
                    end
                    state_reg <= ST_STEP;
                end

                ST_STEP:
                begin
                    travelled_reg <= next_cross_reg[axis_reg];
                    cur_voxel_reg[axis_reg] <= cur_voxel_reg[axis_reg]
                        + (step_sign_reg[axis_reg] ? {CIB{1'b1}} : CIB'(1));
                    next_cross_reg[axis_reg] <= cross_sum[32] ? vrt_pkg::DIST_SAT
                                                              : cross_sum[31:0];
                    face_reg      <= face_step;
                    pend_kind_reg <= (next_cross_reg[axis_reg] > range_q)
                                     ? vrt_pkg::KIND_MISS_RANGE : vrt_pkg::KIND_QUERY;
                    state_reg     <= ST_EMIT;
                end

                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_item_reg.kind <= pend_kind_reg;
                        if (pend_kind_reg == vrt_pkg::KIND_QUERY
                            || pend_kind_reg == vrt_pkg::KIND_HIT)
                        begin
                            out_item_reg.voxel_x    <= cur_voxel_reg[0];
                            out_item_reg.voxel_y    <= cur_voxel_reg[1];
                            out_item_reg.voxel_z    <= cur_voxel_reg[2];
                            out_item_reg.entry_face <= face_reg;
                        end
                        else
                        begin
                            out_item_reg.voxel_x    <= '0;
                            out_item_reg.voxel_y    <= '0;
                            out_item_reg.voxel_z    <= '0;
                            out_item_reg.entry_face <= '0;
                        end
                        if (pend_kind_reg != vrt_pkg::KIND_QUERY)
                        begin
                            ray_active_reg <= 1'b0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== verif/voxel_ray_traversal_top_tb.sv =====
// Self-checking testbench for voxel_ray_traversal_top: random and directed rays,
// answers and noise, checked against an in-bench DDA predictor.
// Depends on vrt_pkg and the design files.
module voxel_ray_traversal_top_tb;
    import vrt_pkg::*;

    localparam logic [1:0] CELL_UNLOADED = 2'd2;
    localparam logic [1:0] CELL_SPARE    = 2'd3;
    localparam int         WATCHDOG_MAX  = 20000;
    localparam int         CFG_SETTLE    = 400;

    typedef struct
    {
        bit                    neg;
        logic [63:0]           mag;
    } sgn_mag_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_item;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;

    voxel_ray_traversal_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ---------------------------------------------------------------
    // Predictor state: its own copy of the registers and the walker
    // ---------------------------------------------------------------
    logic [31:0] sin_tbl [0:QUARTER];
    logic [15:0] range_cfg;
    logic [9:0]  height_cfg;
    logic [23:0] vox [3];
    bit          neg_step [3];
    logic [63:0] cross_at [3];
    logic [63:0] cross_inc [3];
    logic [63:0] dist_done;
    logic [2:0]  face_now;
    bit          ray_live;

    in_item_t  stim_q [$];   // items waiting for the driver
    out_item_t result_q [$]; // predicted results not yet seen
    int        errors;
    bit        idle_on;      // random gaps/stalls enabled for this phase

    // Quarter-wave sine, Q2.30, Taylor series with truncation, capped at 1.0
    function automatic void fill_sine();
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] dv [6];
        dv = '{156, 110, 72, 42, 20, 6};
        for (int i = 0; i <= QUARTER; i++)
        begin
            x  = (64'(i) * 64'd1686629713) >> (ANGLE_BITS - 2);
            x2 = (x * x) >> 30;
            t  = 64'd1 << 30;
            for (int k = 0; k < 6; k++)
            begin
                t = (64'd1 << 30) - ((x2 * t) >> 30) / dv[k];
            end
            s = (x * t) >> 30;
            if (s > (64'd1 << 30))
            begin
                s = 64'd1 << 30;
            end
            sin_tbl[i] = s[31:0];
        end
    endfunction

    function automatic sgn_mag_t sine_of(logic [ANGLE_BITS-1:0] a);
        sgn_mag_t r;
        logic [1:0] quad;
        int rem;
        quad  = a[ANGLE_BITS-1 -: 2];
        rem   = int'(a[ANGLE_BITS-3:0]);
        r.mag = quad[0] ? 64'(sin_tbl[QUARTER - rem]) : 64'(sin_tbl[rem]);
        r.neg = quad[1];
        return r;
    endfunction

    function automatic sgn_mag_t sm_mul(sgn_mag_t a, sgn_mag_t b);
        sgn_mag_t r;
        r.mag = (a.mag * b.mag) >> 30;
        r.neg = a.neg != b.neg;
        return r;
    endfunction

    // Reciprocal distance, saturating on tiny components or 32-bit overflow
    function automatic logic [63:0] recip_dist(logic [63:0] num, logic [63:0] mag);
        logic [63:0] q;
        if (mag < 64'd1074)
        begin
            return 64'hFFFF_FFFF;
        end
        q = num / mag;
        return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
    endfunction

    function automatic logic [63:0] range_dist();
        return 64'(range_cfg) << (DIST_FRAC_BITS - 8);
    endfunction

    function automatic void post_result(logic [1:0] k, bit with_vox);
        out_item_t r;
        r.kind       = k;
        r.voxel_x    = with_vox ? vox[0] : '0;
        r.voxel_y    = with_vox ? vox[1] : '0;
        r.voxel_z    = with_vox ? vox[2] : '0;
        r.entry_face = with_vox ? face_now : '0;
        if (k != KIND_QUERY)
        begin
            ray_live = 0;
        end
        result_q.push_back(r);
    endfunction

    // One DDA step along the axis with the nearest crossing
    function automatic void dda_step();
        int ax;
        logic [63:0] sum;
        if (cross_at[0] < cross_at[1])
        begin
            ax = (cross_at[0] < cross_at[2]) ? 0 : 2;
        end
        else
        begin
            ax = (cross_at[1] < cross_at[2]) ? 1 : 2;
        end
        dist_done = cross_at[ax];
        vox[ax]   = neg_step[ax] ? vox[ax] - 24'd1 : vox[ax] + 24'd1;
        sum       = cross_at[ax] + cross_inc[ax];
        cross_at[ax] = (sum > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : sum;
        face_now  = 3'(2 * ax + (neg_step[ax] ? 0 : 1));
        if (dist_done > range_dist())
        begin
            post_result(KIND_MISS_RANGE, 0);
        end
        else
        begin
            post_result(KIND_QUERY, 1);
        end
    endfunction

    function automatic void predict_transfer(in_item_t it);
        logic [31:0] pos [3];
        sgn_mag_t    dir [3];
        sgn_mag_t    cp;
        logic [63:0] frac;
        logic [63:0] num;
        bit          fwd;
        if (it.operation == OP_START)
        begin
            pos[0] = it.eye_x;
            pos[1] = it.eye_y + 32'(height_cfg);
            pos[2] = it.eye_z;
            cp     = sine_of(it.pitch_angle + ANGLE_BITS'(QUARTER));
            dir[0] = sm_mul(sine_of(it.yaw_angle + ANGLE_BITS'(QUARTER)), cp);
            dir[1] = sine_of(it.pitch_angle);
            dir[2] = sm_mul(sine_of(it.yaw_angle), cp);
            for (int j = 0; j < 3; j++)
            begin
                frac = 64'(pos[j][COORD_FRAC_BITS-1:0]);
                fwd  = (dir[j].mag > 0) && !dir[j].neg;
                num  = fwd ? (64'd1 << COORD_FRAC_BITS) - frac : frac;
                vox[j]       = pos[j][31:8];
                neg_step[j]  = !fwd;
                cross_inc[j] = recip_dist(64'd1 << (30 + DIST_FRAC_BITS), dir[j].mag);
                cross_at[j]  = recip_dist(num << (30 + DIST_FRAC_BITS - COORD_FRAC_BITS),
                                          dir[j].mag);
            end
            dist_done = 0;
            face_now  = 0;
            ray_live  = 1;
            if (range_dist() == 0)
            begin
                post_result(KIND_MISS_RANGE, 0);
            end
            else
            begin
                dda_step();
            end
        end
        else if (ray_live)
        begin
            case (it.cell_state)
                CELL_AIR:
                begin
                    if (dist_done >= range_dist())
                    begin
                        post_result(KIND_MISS_RANGE, 0);
                    end
                    else
                    begin
                        dda_step();
                    end
                end
                CELL_SOLID: post_result(KIND_HIT, 1);
                default:    post_result(KIND_MISS_UNLOAD, 0);
            endcase
        end
    endfunction

    // ---------------------------------------------------------------
    // Stimulus builders
    // ---------------------------------------------------------------
    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return 32'($urandom_range(0, 8191)) - 32'd4096;
            default: return 32'($urandom_range(0, 4095)) - 32'd2048;
        endcase
    endfunction

    function automatic in_item_t start_item(logic [31:0] x, logic [31:0] y,
                                            logic [31:0] z, logic [11:0] yaw,
                                            logic [11:0] pitch);
        in_item_t it;
        it             = '0;
        it.operation   = OP_START;
        it.eye_x       = x;
        it.eye_y       = y;
        it.eye_z       = z;
        it.yaw_angle   = yaw;
        it.pitch_angle = pitch;
        it.cell_state  = 2'($urandom()); // don't care on a start
        return it;
    endfunction

    function automatic in_item_t answer_item(logic [1:0] cs);
        in_item_t it;
        it            = in_item_t'({$urandom(), $urandom(), $urandom(), $urandom()});
        it.operation  = OP_ANSWER;
        it.cell_state = cs;
        return it;
    endfunction

    function automatic in_item_t rand_start();
        logic [11:0] pitch;
        pitch = ($urandom_range(0, 9) == 0) ? 12'($urandom())
                                            : 12'($urandom_range(0, 2048) - 1024);
        return start_item(rand_pos(), rand_pos(), rand_pos(), 12'($urandom()), pitch);
    endfunction

    // Mostly full rays: start, a run of air answers, then an ending answer.
    // Now and then a bare answer or a start dropped in the middle of a ray.
    task automatic queue_rays(int n_items);
        int added;
        int air_run;
        added = 0;
        while (added < n_items)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                stim_q.push_back(answer_item(2'($urandom())));
                added++;
            end
            else
            begin
                stim_q.push_back(rand_start());
                air_run = $urandom_range(0, 14);
                for (int i = 0; i < air_run; i++)
                begin
                    stim_q.push_back(answer_item(CELL_AIR));
                end
                if ($urandom_range(0, 7) != 0)
                begin
                    stim_q.push_back(answer_item(2'($urandom_range(1, 3))));
                end
                added += air_run + 2;
            end
        end
    endtask

    task automatic wait_idle();
        while (stim_q.size() != 0 || in_valid || result_q.size() != 0)
        begin
            @(posedge clk);
        end
        // an ignored answer may still be in the sequencer
        repeat (CFG_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_MAX_RANGE)
        begin
            range_cfg = val;
        end
        else
        begin
            height_cfg = val[9:0];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Clock and reset
    // ---------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // ---------------------------------------------------------------
    // Driver: one transfer at a time from stim_q, random gap per item
    // ---------------------------------------------------------------
    int in_gap;

    always @(posedge clk or negedge rst_n)
    begin
        logic nxt_valid;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap   <= 0;
        end
        else
        begin
            nxt_valid = in_valid;
            if (in_valid && in_ready)
            begin
                predict_transfer(in_item);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (in_gap > 0)
                begin
                    in_gap <= in_gap - 1;
                end
                else if (stim_q.size() != 0)
                begin
                    in_item   <= stim_q.pop_front();
                    nxt_valid = 1'b1;
                    in_gap    <= idle_on ? $urandom_range(0, 17) : 0;
                end
            end
            in_valid <= nxt_valid;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: random stall after each result, compare against result_q
    // ---------------------------------------------------------------
    int out_stall;

    always @(posedge clk or negedge rst_n)
    begin
        int w;
        out_item_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end
        else if (out_valid && out_ready)
        begin
            if (result_q.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, out_item);
                errors++;
            end
            else
            begin
                want = result_q.pop_front();
                if (out_item !== want)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, out_item);
                    errors++;
                end
            end
            w = idle_on ? $urandom_range(0, 17) : 0;
            out_stall <= w;
            out_ready <= (w == 0);
        end
        else if (out_stall > 0)
        begin
            out_stall <= out_stall - 1;
            out_ready <= (out_stall == 1);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: cycles with no transfer on either side
    // ---------------------------------------------------------------
    int quiet;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet <= 0;
        end
        else if (quiet >= WATCHDOG_MAX)
        begin
            $display("voxel_ray_traversal_top_tb NOT OK");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial
    begin
        logic [15:0] ranges [6];
        logic [9:0]  heights [6];
        errors     = 0;
        quiet      = 0;
        idle_on    = 1'b0;
        rst_n      = 1'b0;
        in_item    = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        range_cfg  = 16'd1280;
        height_cfg = 10'd410;
        vox        = '{default: '0};
        neg_step   = '{default: 0};
        cross_at   = '{default: '0};
        cross_inc  = '{default: '0};
        dist_done  = '0;
        face_now   = '0;
        ray_live   = 0;
        fill_sine();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: answer with no ray, axis-aligned and vertical rays,
        // pitch beyond ninety degrees, extreme positions, odd cell state,
        // a start in the middle of a ray.
        stim_q.push_back(answer_item(CELL_AIR));
        stim_q.push_back(start_item(32'h0000_0080, 0, 32'h0000_0080, 12'd0, 12'd0));
        for (int i = 0; i < 4; i++)
        begin
            stim_q.push_back(answer_item(CELL_AIR));
        end
        stim_q.push_back(answer_item(CELL_SOLID));
        stim_q.push_back(start_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    12'd1024, 12'd1024));
        stim_q.push_back(answer_item(CELL_AIR));
        stim_q.push_back(answer_item(CELL_SPARE));
        stim_q.push_back(start_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                    12'd2048, 12'hC00));
        stim_q.push_back(answer_item(CELL_AIR));
        stim_q.push_back(start_item(32'hFFFF_FF00, 32'h0000_00FF, 32'hFFFF_FFFF,
                                    12'd3072, 12'h7FF));
        stim_q.push_back(answer_item(CELL_AIR));
        stim_q.push_back(answer_item(CELL_UNLOADED));
        stim_q.push_back(answer_item(CELL_AIR)); // ray already over
        stim_q.push_back(start_item(0, 0, 0, 12'hFFF, 12'h800));
        stim_q.push_back(answer_item(CELL_SOLID));
        wait_idle();

        ranges  = '{16'd0, 16'd65535, 16'd1280, 16'd16, 16'($urandom()), 16'd3000};
        heights = '{10'd0, 10'd1023, 10'd410, 10'($urandom()), 10'd700, 10'($urandom())};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_MAX_RANGE, ranges[ph]);
            write_reg(REG_EYE_HEIGHT, 16'(heights[ph]));
            idle_on = (ph % 3 != 2);
            queue_rays(265);
            wait_idle();
        end

        if (errors == 0)
        begin
            $display("voxel_ray_traversal_top_tb OK");
        end
        else
        begin
            $display("voxel_ray_traversal_top_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== voxel_ray_traversal_top.f =====
design/vrt_pkg.sv
design/vrt_div.sv
design/voxel_ray_traversal_top.sv
verif/voxel_ray_traversal_top_tb.sv
